// ----- rtl/shift_jis_to_unicode_decoder_macros.svh -----
// Assertion macros shared by the checker of the Shift_JIS decoder.
`ifndef SHIFT_JIS_TO_UNICODE_DECODER_MACROS_SVH
`define SHIFT_JIS_TO_UNICODE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SJD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sjis decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SJD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sjis decoder: next-cycle check failed");

`endif

// ----- rtl/sjd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sjd_pkg;

   localparam int CODE_W  = 16;
   localparam int PTR_W   = 14;
   localparam int POINT_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic OPCODE_LOAD    = 1'b0;
   localparam logic OPCODE_CONVERT = 1'b1;

   localparam logic [PTR_W-1:0]   ROW_LENGTH    = 14'd188;
   localparam logic [PTR_W-1:0]   PUA_FIRST_PTR = 14'd8836;
   localparam logic [PTR_W-1:0]   PUA_LAST_PTR  = 14'd10715;
   localparam logic [POINT_W-1:0] PUA_BASE      = 16'hE000;
   localparam logic [POINT_W-1:0] KANA_BASE     = 16'hFF61;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_DIRECT = 2'd1,
      KIND_LOOKUP = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [PTR_W-1:0]   addr;
      logic [POINT_W-1:0] value;
      logic               error;
      logic               present;
   } op_type;

   typedef struct packed {
      logic [POINT_W-1:0] value;
      logic               error;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic q_full;
   } front_status_type;

endpackage

`default_nettype wire

// ----- rtl/sjd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sjd_front import sjd_pkg::*; #(
   parameter int TABLE_ENTRIES = 16384
) (
   input  wire                    req_push,
   output logic                   req_full,
   input  wire                    req_opcode,
   input  wire  [CODE_W-1:0]      req_sjis_code,
   input  wire  [PTR_W-1:0]       req_entry_index,
   input  wire  [POINT_W-1:0]     req_entry_value,
   input  wire                    req_entry_present,
   input  front_status_type       status,
   output logic                   q_push,
   output op_type                 q_data
);

   logic [7:0]       lead;
   logic [7:0]       trail;
   logic [5:0]       lead_row;
   logic [7:0]       trail_col;
   logic [PTR_W-1:0] ptr;
   logic             lead_ok;
   logic             trail_ok;
   logic             accept;
   logic             index_ok;
   op_type           conv_op;

   assign req_full = status.clearing || status.q_full;
   assign accept   = req_push && !req_full;
   assign index_ok = {1'b0, req_entry_index} < (PTR_W+1)'(TABLE_ENTRIES);

   assign lead      = req_sjis_code[15:8];
   assign trail     = req_sjis_code[7:0];
   assign lead_ok   = (lead inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
   assign trail_ok  = (trail inside {[8'h40:8'h7E], [8'h80:8'hFC]});
   assign lead_row  = (lead < 8'hA0) ? 6'(lead - 8'h81) : 6'(lead - 8'hC1);
   assign trail_col = (trail < 8'h7F) ? 8'(trail - 8'h40) : 8'(trail - 8'h41);
   assign ptr       = PTR_W'(PTR_W'(lead_row) * ROW_LENGTH + PTR_W'(trail_col));

   always_comb begin
      conv_op.kind    = KIND_DIRECT;
      conv_op.addr    = ptr;
      conv_op.value   = '0;
      conv_op.error   = 1'b0;
      conv_op.present = 1'b0;
      if (req_sjis_code <= 16'h0080) begin
         conv_op.value = req_sjis_code;
      end else begin
         case (req_sjis_code)
            16'h815C: conv_op.value = 16'h2014;
            16'h8160: conv_op.value = 16'h301C;
            16'h8161: conv_op.value = 16'h2016;
            16'h817C: conv_op.value = 16'h2212;
            16'h8191: conv_op.value = 16'h00A2;
            16'h8192: conv_op.value = 16'h00A3;
            16'h81CA: conv_op.value = 16'h00AC;
            default: begin
               if (req_sjis_code inside {[16'h8740:16'h879C], [16'hED40:16'hFFFF]}) begin
                  conv_op.error = 1'b1;
               end else if (req_sjis_code inside {[16'h00A1:16'h00DF]}) begin
                  conv_op.value = POINT_W'(req_sjis_code - 16'h00A1 + KANA_BASE);
               end else if (!lead_ok || !trail_ok) begin
                  conv_op.error = 1'b1;
               end else if (ptr >= PUA_FIRST_PTR && ptr <= PUA_LAST_PTR) begin
                  conv_op.value = POINT_W'(PUA_BASE + POINT_W'(ptr) - POINT_W'(PUA_FIRST_PTR));
               end else if ({1'b0, ptr} >= (PTR_W+1)'(TABLE_ENTRIES)) begin
                  conv_op.error = 1'b1;
               end else begin
                  conv_op.kind = KIND_LOOKUP;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (req_opcode == OPCODE_CONVERT) begin
         q_data = conv_op;
         q_push = accept;
      end else begin
         q_data.kind    = KIND_LOAD;
         q_data.addr    = req_entry_index;
         q_data.value   = req_entry_value;
         q_data.error   = 1'b0;
         q_data.present = req_entry_present;
         q_push         = accept && index_ok;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sjd_op_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sjd_op_queue import sjd_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   input  op_type      push_data,
   output logic        full,
   input  wire         pop,
   output op_type      pop_data,
   output logic        empty
);

   op_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = do_pop ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      count_in = QCNT_W'(count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sjd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sjd_back import sjd_pkg::*; #(
   parameter int TABLE_ENTRIES = 16384
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_empty,
   input  op_type               q_data,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output logic [POINT_W-1:0]   rsp_unicode_point,
   output logic                 rsp_conv_error
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int WORD_W = POINT_W + 1;

   logic [WORD_W-1:0]   table_mem [TABLE_ENTRIES];
   logic [WORD_W-1:0]   rd_ff;
   logic                mem_we;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_addr;
   logic [WORD_W-1:0]   mem_wdata;

   logic                clearing_ff, clearing_in;
   logic [ADDR_W-1:0]   clear_addr_ff, clear_addr_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_lookup_ff;
   logic [POINT_W-1:0]  s1_value_ff;
   logic                s1_error_ff;

   result_type          out_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   out_wptr_ff, out_wptr_in;
   logic [QPTR_W-1:0]   out_rptr_ff, out_rptr_in;
   logic [QCNT_W-1:0]   out_count_ff, out_count_in;
   logic                out_push;
   logic                out_pop;
   result_type          out_data;
   logic                credit_ok;

   assign clearing = clearing_ff;

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = ADDR_W'(clear_addr_ff + 1'b1);
         if (clear_addr_ff == ADDR_W'(TABLE_ENTRIES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign credit_ok = (QCNT_W'(out_count_ff + QCNT_W'(s1_valid_ff))) < QCNT_W'(QUEUE_DEPTH);
   assign q_pop     = !clearing_ff && !q_empty && (q_data.kind == KIND_LOAD || credit_ok);

   always_comb begin
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = q_data.addr[ADDR_W-1:0];
      mem_wdata   = {q_data.present, q_data.value};
      s1_valid_in = 1'b0;
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_addr  = clear_addr_ff;
         mem_wdata = '0;
      end else if (q_pop) begin
         case (q_data.kind)
            KIND_LOAD:   mem_we = 1'b1;
            KIND_LOOKUP: begin
               mem_re      = 1'b1;
               s1_valid_in = 1'b1;
            end
            KIND_DIRECT: s1_valid_in = 1'b1;
            default:     s1_valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= table_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_lookup_ff <= q_data.kind == KIND_LOOKUP;
         s1_value_ff  <= q_data.value;
         s1_error_ff  <= q_data.error;
      end
   end

   always_comb begin
      out_data.value = s1_value_ff;
      out_data.error = s1_error_ff;
      if (s1_lookup_ff) begin
         out_data.value = rd_ff[WORD_W-1] ? rd_ff[POINT_W-1:0] : '0;
         out_data.error = !rd_ff[WORD_W-1];
      end
   end

   assign out_push          = s1_valid_ff;
   assign rsp_empty         = out_count_ff == '0;
   assign out_pop           = rsp_pop && !rsp_empty;
   assign rsp_unicode_point = out_ff[out_rptr_ff].value;
   assign rsp_conv_error    = out_ff[out_rptr_ff].error;

   always_comb begin
      out_wptr_in  = out_push ? QPTR_W'(out_wptr_ff + 1'b1) : out_wptr_ff;
      out_rptr_in  = out_pop ? QPTR_W'(out_rptr_ff + 1'b1) : out_rptr_ff;
      out_count_in = QCNT_W'(out_count_ff + QCNT_W'(out_push) - QCNT_W'(out_pop));
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wptr_ff] <= out_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_wptr_ff   <= '0;
         out_rptr_ff   <= '0;
         out_count_ff  <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         out_wptr_ff   <= out_wptr_in;
         out_rptr_ff   <= out_rptr_in;
         out_count_ff  <= out_count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/shift_jis_to_unicode_decoder.sv -----
// Shift_JIS to Unicode decoder with a loadable jis0208 table.
// Input queue: drive the req_ fields and raise req_push; a beat is taken at a
// rising edge where req_push is high and req_full is low. A load beat
// (opcode 0) writes a table entry if its index is below TABLE_ENTRIES, and
// gives no result; a convert beat (opcode 1) gives exactly one result.
// Result queue: while rsp_empty is low the oldest result stands on the rsp_
// ports, and it is taken at an edge where rsp_pop is high.
// A convert beat's result passes the inner queue, s1 and the result queue.
// One beat is taken in every cycle while req_full is low; the table memory
// has a single port, used for a load's write, a lookup's read or clearing.
// After reset the table is cleared one entry a cycle; req_full stays high
// throughout.
// If the receiver stops popping, four results collect at the output and four
// beats in the inner queue, after which req_full rises; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module shift_jis_to_unicode_decoder import sjd_pkg::*; #(
   parameter int TABLE_ENTRIES = 16384
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  wire                  req_opcode,
   input  wire  [CODE_W-1:0]    req_sjis_code,
   input  wire  [PTR_W-1:0]     req_entry_index,
   input  wire  [POINT_W-1:0]   req_entry_value,
   input  wire                  req_entry_present,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output logic [POINT_W-1:0]   rsp_unicode_point,
   output logic                 rsp_conv_error
);

   front_status_type front_status;
   logic             q_push;
   op_type           q_push_data;
   logic             q_full;
   logic             q_pop;
   op_type           q_pop_data;
   logic             q_empty;
   logic             clearing;

   assign front_status.clearing = clearing;
   assign front_status.q_full   = q_full;

   sjd_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_sjis_code    (req_sjis_code),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_entry_present(req_entry_present),
      .status           (front_status),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   sjd_op_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty)
   );

   sjd_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_unicode_point(rsp_unicode_point),
      .rsp_conv_error   (rsp_conv_error)
   );

endmodule

`default_nettype wire

// ----- rtl/sjd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "shift_jis_to_unicode_decoder_macros.svh"

module sjd_checker import sjd_pkg::*; (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_full,
   input wire                 rsp_empty,
   input wire                 rsp_pop,
   input wire [POINT_W-1:0]   rsp_unicode_point,
   input wire                 rsp_conv_error
);

   logic waiting;

   assign waiting = !rsp_empty && !rsp_pop;

   `SJD_ASSERT_NOW(full_after_reset, clock, reset, $past(reset), req_full)
   `SJD_ASSERT_NOW(empty_after_reset, clock, reset, $past(reset), rsp_empty)
   `SJD_ASSERT_NOW(error_gives_zero, clock, reset, !rsp_empty && rsp_conv_error, rsp_unicode_point == '0)
   `SJD_ASSERT_NEXT(stalled_point_holds, clock, reset, waiting, !rsp_empty && $stable(rsp_unicode_point))
   `SJD_ASSERT_NEXT(stalled_error_holds, clock, reset, waiting, $stable(rsp_conv_error))

endmodule

bind shift_jis_to_unicode_decoder sjd_checker u_checker (.*);

`default_nettype wire
